@@ rtl/cbc_pkg.sv @@
// -----------------------------------------------------------------------------
// cbc_pkg
// Types, codes and helper functions shared by the cartridge bank controller.
// -----------------------------------------------------------------------------
package cbc_pkg;

    // mapper kinds
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_MBC1 = 3'd1;
    localparam logic [2:0] KIND_MBC2 = 3'd2;
    localparam logic [2:0] KIND_MBC3 = 3'd3;
    localparam logic [2:0] KIND_MBC5 = 3'd4;

    // target codes
    localparam logic [2:0] TGT_OTHER = 3'd0;
    localparam logic [2:0] TGT_BOOT  = 3'd1;
    localparam logic [2:0] TGT_ROM   = 3'd2;
    localparam logic [2:0] TGT_RAM   = 3'd3;
    localparam logic [2:0] TGT_OPEN  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_MAPPER_KIND    = 2'd0;
    localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd1;
    localparam logic [1:0] CFG_RAM_BYTES      = 2'd2;

    localparam int CFG_DATA_W = 18;

    // special counts and addresses
    localparam logic [9:0]  ROM_BANKS_64  = 10'd64;
    localparam logic [9:0]  ROM_BANKS_128 = 10'd128;
    localparam logic [17:0] RAM_BANK_BYTES = 18'd8192;
    localparam logic [3:0]  RAM_EN_KEY    = 4'hA;
    localparam logic [15:0] ADDR_JOYPAD   = 16'hFF00;
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;

    typedef struct packed {
        logic [2:0]  mapper_kind;
        logic [9:0]  rom_bank_count;
        logic [17:0] ram_bytes;
    } t_cfg;

    typedef struct packed {
        logic        cmd;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } t_access;

    typedef struct packed {
        logic [2:0]  target;
        logic [22:0] mapped_offset;
        logic        store_enable;
        logic        nibble_only;
    } t_result;

    // MBC1 bank mask from the ROM size
    function automatic logic [4:0] mbc1_mask(input logic [9:0] count);
        logic [4:0] m;
        if (count >= 10'd32)      m = 5'h1F;
        else if (count >= 10'd16) m = 5'h0F;
        else if (count >= 10'd8)  m = 5'h07;
        else if (count >= 10'd4)  m = 5'h03;
        else if (count >= 10'd2)  m = 5'h01;
        else                      m = 5'h00;
        return m;
    endfunction

    // fold RAM-bank bits into the ROM bank for 64 and 128 bank ROMs
    function automatic logic [8:0] fold_bank(input logic [8:0] rom,
                                             input logic [7:0] ram,
                                             input logic [9:0] count);
        logic [8:0] b;
        b = rom;
        if (count == ROM_BANKS_64)  b = {rom[8:6], ram[0], rom[4:0]};
        if (count == ROM_BANKS_128) b = {rom[8:7], ram[1:0], rom[4:0]};
        return b;
    endfunction

endpackage

@@ rtl/cbc_req_if.sv @@
// -----------------------------------------------------------------------------
// cbc_req_if
// Request channel: one CPU bus access per transfer.
// -----------------------------------------------------------------------------
interface cbc_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;

    modport source (output valid, output cmd, output bus_address, output write_byte,
                    input ready);
    modport sink   (input valid, input cmd, input bus_address, input write_byte,
                    output ready);
endinterface

@@ rtl/cbc_rsp_if.sv @@
// -----------------------------------------------------------------------------
// cbc_rsp_if
// Response channel: where one access lands.
// -----------------------------------------------------------------------------
interface cbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [22:0] mapped_offset;
    logic        store_enable;
    logic        nibble_only;

    modport source (output valid, output target, output mapped_offset,
                    output store_enable, output nibble_only, input ready);
    modport sink   (input valid, input target, input mapped_offset,
                    input store_enable, input nibble_only, output ready);
endinterface

@@ rtl/cartridge_bank_controller.sv @@
// -----------------------------------------------------------------------------
// cartridge_bank_controller
// MBC1/MBC2/MBC3/MBC5 style bank controller translating CPU bus accesses.
// -----------------------------------------------------------------------------
// Usage:
//   i_req carries one CPU access per request (cmd, bus_address, write_byte).
//   o_rsp returns one response per request, in order: target store, byte
//   offset in that store, store enable and the MBC2 nibble flag.
//   Configuration (mapper kind, ROM bank count, RAM bytes) is written through
//   i_cfg_we / i_cfg_index / i_cfg_data while no request is in flight.
// Pipeline and throughput:
//   Stages: r_acc0, r_acc1, r_acc2, r_res. One request is taken every cycle
//   while the output does not stall; the RAM-size remainder is spread over two
//   stages; the bank registers are read and updated once per request at r_acc2.
// Reset:
//   Synchronous, active low. Clears the pipeline, the configuration and the
//   bank registers (ROM bank 1, boot ROM overlay mapped).
// Stall:
//   When o_rsp.ready is low the response holds; earlier stages fill up and
//   i_req.ready drops once every stage is occupied.
// -----------------------------------------------------------------------------
module cartridge_bank_controller
    import cbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cbc_req_if.sink               i_req,
    cbc_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    t_access     r_acc0;
    t_access     r_acc1;
    t_access     r_acc2;
    logic        r_v0;
    logic        r_v1;
    logic        r_v2;
    logic        r_out_valid;
    t_result     r_res;

    t_access     in_acc;
    t_result     core_res;
    logic [12:0] wrap_rem;
    logic        rdy_out;
    logic        rdy2;
    logic        rdy1;
    logic        acc_in;
    logic        adv1;
    logic        adv2;
    logic        adv3;

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAPPER_KIND:    r_cfg.mapper_kind    <= i_cfg_data[2:0];
                CFG_ROM_BANK_COUNT: r_cfg.rom_bank_count <= i_cfg_data[9:0];
                CFG_RAM_BYTES:      r_cfg.ram_bytes      <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // ---- flow control: a stage advances when the next one is free or draining
    assign rdy_out = !r_out_valid || o_rsp.ready;
    assign rdy2    = !r_v2 || rdy_out;
    assign rdy1    = !r_v1 || rdy2;
    assign i_req.ready = !r_v0 || rdy1;

    assign acc_in = i_req.valid && i_req.ready;
    assign adv1   = r_v0 && rdy1;
    assign adv2   = r_v1 && rdy2;
    assign adv3   = r_v2 && rdy_out;

    assign in_acc.cmd         = i_req.cmd;
    assign in_acc.bus_address = i_req.bus_address;
    assign in_acc.write_byte  = i_req.write_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc_in)    r_v0 <= 1'b1;
            else if (adv1) r_v0 <= 1'b0;
            if (adv1)      r_v1 <= 1'b1;
            else if (adv2) r_v1 <= 1'b0;
            if (adv2)      r_v2 <= 1'b1;
            else if (adv3) r_v2 <= 1'b0;
            if (adv3)             r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    // ---- request payload down the pipe
    always_ff @(posedge i_clk) begin
        if (acc_in) r_acc0 <= in_acc;
        if (adv1)   r_acc1 <= r_acc0;
        if (adv2)   r_acc2 <= r_acc1;
        if (adv3)   r_res  <= core_res;
    end

    // ---- RAM window offset modulo RAM size (used for RAM of 8 KiB or less)
    cbc_ram_wrap u_wrap (
        .i_clk     (i_clk),
        .i_offset  (r_acc0.bus_address[12:0]),
        .i_modulus (r_cfg.ram_bytes[13:0]),
        .i_adv1    (adv1),
        .i_adv2    (adv2),
        .o_rem     (wrap_rem)
    );

    // ---- bank registers and mapping, committed once per request
    cbc_map_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_acc    (r_acc2),
        .i_rem    (wrap_rem),
        .i_commit (adv3),
        .o_res    (core_res)
    );

    // ---- response
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.target        = r_res.target;
    assign o_rsp.mapped_offset = r_res.mapped_offset;
    assign o_rsp.store_enable  = r_res.store_enable;
    assign o_rsp.nibble_only   = r_res.nibble_only;

    // ---- checks
    a_no_offset_off_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.target == TGT_OTHER || o_rsp.target == TGT_OPEN)
        |-> o_rsp.mapped_offset == '0)
        else $error("offset set for a target without a store");

    a_store_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.store_enable
        |-> (o_rsp.target == TGT_RAM || o_rsp.target == TGT_OTHER))
        else $error("store enable on a read-only target");

    a_nibble_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.nibble_only == (r_cfg.mapper_kind == KIND_MBC2))
        else $error("nibble flag disagrees with mapper kind");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && rdy_out |=> r_out_valid)
        else $error("response lost between last stage and output");

endmodule

@@ rtl/cbc_ram_wrap.sv @@
// -----------------------------------------------------------------------------
// cbc_ram_wrap
// Two-stage restoring remainder of a RAM window offset by the RAM size.
// -----------------------------------------------------------------------------
module cbc_ram_wrap
    import cbc_pkg::*;
(
    input  logic        i_clk,
    input  logic [12:0] i_offset,
    input  logic [13:0] i_modulus,
    input  logic        i_adv1,
    input  logic        i_adv2,
    output logic [12:0] o_rem
);

    logic [12:0] r_part;
    logic [5:0]  r_tail;
    logic [12:0] r_rem;
    logic [12:0] n_part;
    logic [12:0] n_rem;

    // first seven quotient bits
    always_comb begin
        logic [13:0] t;
        n_part = '0;
        for (int k = 12; k >= 6; k--) begin
            t = {n_part, i_offset[k]};
            if (t >= i_modulus) t = t - i_modulus;
            n_part = t[12:0];
        end
    end

    // last six quotient bits
    always_comb begin
        logic [13:0] t;
        n_rem = r_part;
        for (int k = 5; k >= 0; k--) begin
            t = {n_rem, r_tail[k]};
            if (t >= i_modulus) t = t - i_modulus;
            n_rem = t[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv1) begin
            r_part <= n_part;
            r_tail <= i_offset[5:0];
        end
        if (i_adv2) begin
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

@@ rtl/cbc_map_core.sv @@
// -----------------------------------------------------------------------------
// cbc_map_core
// Bank registers, their write rules and the address mapping of one access.
// -----------------------------------------------------------------------------
module cbc_map_core
    import cbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_access     i_acc,
    input  logic [12:0] i_rem,
    input  logic        i_commit,
    output t_result     o_res
);

    logic       r_ram_en;
    logic [8:0] r_rom_bank;
    logic [7:0] r_ram_bank;
    logic       r_mode;
    logic       r_boot;

    logic       w_ram_en;
    logic [8:0] w_rom_bank;
    logic [7:0] w_ram_bank;
    logic       w_mode;
    logic [8:0] fold;
    logic [8:0] n_rom_bank;
    logic       n_boot;

    logic [15:0] a;
    logic [7:0]  v;
    logic [4:0]  b5;
    logic [3:0]  b4;
    logic [6:0]  b7;
    logic [1:0]  zb;

    assign a  = i_acc.bus_address;
    assign v  = i_acc.write_byte;
    assign b5 = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
    assign b4 = (v[3:0] == 4'd0) ? 4'd1 : v[3:0];
    assign b7 = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];

    // mapper register writes
    always_comb begin
        w_ram_en   = r_ram_en;
        w_rom_bank = r_rom_bank;
        w_ram_bank = r_ram_bank;
        w_mode     = r_mode;
        if (i_acc.cmd && !a[15]) begin
            case (i_cfg.mapper_kind)
                KIND_MBC1: begin
                    case (a[14:13])
                        2'b00:   w_ram_en   = (v[3:0] == RAM_EN_KEY);
                        2'b01:   w_rom_bank = {4'd0, b5 & mbc1_mask(i_cfg.rom_bank_count)};
                        2'b10:   w_ram_bank = {6'd0, v[1:0]};
                        default: w_mode     = v[0];
                    endcase
                end
                KIND_MBC2: begin
                    if (!a[14]) begin
                        if (!a[8]) w_ram_en   = (v[3:0] == RAM_EN_KEY);
                        else       w_rom_bank = {5'd0, b4};
                    end
                end
                KIND_MBC3: begin
                    case (a[14:13])
                        2'b00:   w_ram_en   = (v[3:0] == RAM_EN_KEY);
                        2'b01:   w_rom_bank = {2'd0, b7};
                        2'b10:   if (v <= 8'd3) w_ram_bank = v;
                        default: ;
                    endcase
                end
                KIND_MBC5: begin
                    case (a[14:13])
                        2'b00:   w_ram_en = (v[3:0] == RAM_EN_KEY);
                        2'b01:   begin
                            if (!a[12]) w_rom_bank = {r_rom_bank[8], v};
                            else        w_rom_bank = {v[0], r_rom_bank[7:0]};
                        end
                        2'b10:   w_ram_bank = v;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign fold = fold_bank(w_rom_bank, w_ram_bank, i_cfg.rom_bank_count);

    always_comb begin
        zb = 2'd0;
        if (w_mode) begin
            if (i_cfg.rom_bank_count == ROM_BANKS_64)  zb = {1'b0, w_ram_bank[0]};
            if (i_cfg.rom_bank_count == ROM_BANKS_128) zb = w_ram_bank[1:0];
        end
    end

    // address mapping
    always_comb begin
        o_res.target        = TGT_OTHER;
        o_res.mapped_offset = '0;
        o_res.store_enable  = 1'b0;
        o_res.nibble_only   = (i_cfg.mapper_kind == KIND_MBC2);
        if (a[15:14] == 2'b00) begin
            if (a[15:8] == 8'd0 && r_boot) begin
                o_res.target        = TGT_BOOT;
                o_res.mapped_offset = {7'd0, a};
            end else begin
                o_res.target        = TGT_ROM;
                o_res.mapped_offset = {2'd0, zb, 5'd0, a[13:0]};
            end
        end else if (a[15:14] == 2'b01) begin
            o_res.target        = TGT_ROM;
            o_res.mapped_offset = {fold, a[13:0]};
        end else if (a[15:13] == 3'b101) begin
            if (!w_ram_en) begin
                o_res.target = TGT_OPEN;
            end else if (i_cfg.mapper_kind == KIND_MBC2) begin
                o_res.target        = TGT_RAM;
                o_res.mapped_offset = {14'd0, a[8:0]};
            end else if (i_cfg.ram_bytes == '0) begin
                o_res.target = TGT_OPEN;
            end else if (i_cfg.ram_bytes <= RAM_BANK_BYTES) begin
                o_res.target        = TGT_RAM;
                o_res.mapped_offset = {10'd0, i_rem};
            end else if (w_mode) begin
                o_res.target        = TGT_RAM;
                o_res.mapped_offset = {7'd0, w_ram_bank[2:0], a[12:0]};
            end else begin
                o_res.target        = TGT_RAM;
                o_res.mapped_offset = {10'd0, a[12:0]};
            end
            o_res.store_enable = i_acc.cmd && (o_res.target == TGT_RAM);
        end else if (a >= 16'hFEA0 && a <= 16'hFEFF) begin
            o_res.target = TGT_OPEN;
        end else begin
            o_res.store_enable = i_acc.cmd && (a != ADDR_JOYPAD);
        end
    end

    // a read of the switchable window keeps the folded bank
    assign n_rom_bank = (!i_acc.cmd && a[15:14] == 2'b01) ? fold : w_rom_bank;
    assign n_boot     = r_boot && !(i_acc.cmd && a == ADDR_BOOT_OFF && v == 8'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_en   <= 1'b0;
            r_rom_bank <= 9'd1;
            r_ram_bank <= 8'd0;
            r_mode     <= 1'b0;
            r_boot     <= 1'b1;
        end else if (i_commit) begin
            r_ram_en   <= w_ram_en;
            r_rom_bank <= n_rom_bank;
            r_ram_bank <= w_ram_bank;
            r_mode     <= w_mode;
            r_boot     <= n_boot;
        end
    end

endmodule
